// ===== src/safm_pkg.sv =====
`timescale 1ns / 1ps

package safm_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LEVEL_BITS      = 12;
  localparam int ANGLE_BITS      = 16;
  localparam int GAIN_BITS       = 16;
  localparam int FACTOR_BITS     = 8;
  localparam int WINDOW_BITS     = 8;
  localparam int SUM_BITS        = 20;
  localparam int CMP_BITS        = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;

  // The mean divider retires one quotient bit per step.
  localparam int DIV_STEPS = SUM_BITS;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LPF_FACTOR   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEAN_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_LEVEL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_GAIN    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_OFFSET  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_GAIN   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_OFFSET = 3'd7;

  // Filter mode codes.
  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_LPF  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic                          RST_FILTER_MODE  = MODE_LPF;
  localparam logic [FACTOR_BITS-1:0]        RST_LPF_FACTOR   = 8'd230;
  localparam logic [WINDOW_BITS-1:0]        RST_MEAN_WINDOW  = 8'd20;
  localparam logic [LEVEL_BITS-1:0]         RST_CENTER_LEVEL = 12'd1350;
  localparam logic [GAIN_BITS-1:0]          RST_LEFT_GAIN    = 16'd2320;
  localparam logic signed [ANGLE_BITS-1:0]  RST_LEFT_OFFSET  = -16'sd12237;
  localparam logic [GAIN_BITS-1:0]          RST_RIGHT_GAIN   = 16'd1874;
  localparam logic signed [ANGLE_BITS-1:0]  RST_RIGHT_OFFSET = -16'sd9907;

  typedef struct packed {
    logic                          filter_mode;
    logic [FACTOR_BITS-1:0]        lpf_factor;
    logic [WINDOW_BITS-1:0]        mean_window;
    logic [LEVEL_BITS-1:0]         center_level;
    logic [GAIN_BITS-1:0]          left_gain;
    logic signed [ANGLE_BITS-1:0]  left_offset;
    logic [GAIN_BITS-1:0]          right_gain;
    logic signed [ANGLE_BITS-1:0]  right_offset;
  } cfg_t;

  // What the back part has to do for one item.
  typedef enum logic [1:0] {
    ITEM_LPF,
    ITEM_MEAN_HOLD,
    ITEM_MEAN_CLOSE
  } item_kind_t;

  // For a low-pass item, operand holds the sample; for a closing window it
  // holds the window sum and divisor holds the window length.
  typedef struct packed {
    item_kind_t             kind;
    logic [SUM_BITS-1:0]    operand;
    logic [WINDOW_BITS-1:0] divisor;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LPF_MUL,
    BK_LPF_SUM,
    BK_DIV,
    BK_MAP_MUL,
    BK_MAP_ADD
  } back_state_t;

endpackage

// ===== src/steer_angle_filter_and_map.sv =====
`timescale 1ns / 1ps

// Steering angle filter and calibration map.
//
// One raw ADC sample arrives per transfer on the sample channel (sample_valid,
// sample_stall). Each sample yields exactly one transfer on the result
// channel: the filtered level, the angle in signed Q8.8 degrees and the side
// of the calibration line that was used.
// A front part accepts samples, keeps the running window sum and count, and
// queues a tagged item; a back part runs the low-pass multiply, the 20-step
// restoring divider for the mean, and the line mapping with saturation.
// A low-pass item runs the multiply and sum states, a window-closing mean
// item runs the divider, and a mean sample that does not close a window goes
// straight to the mapping. The back sequencer handles one item at a time, so
// it takes a new item from the queue only once the last result is loaded
// into the output register.
// A two-entry queue plus the output register lets the front keep accepting
// while a result is stalled; sample_stall rises once the queue is full.
// Synchronous reset clears the filter state, window sum and count, restores
// register defaults and empties the queue and output register.
// Registers are written through cfg_valid/cfg_ready, which is always ready;
// write them only while no samples are in flight.

module steer_angle_filter_and_map #(
  parameter int SAMPLE_BITS = safm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic [SAMPLE_BITS-1:0]                 sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [safm_pkg::LEVEL_BITS-1:0]        filtered_level,
  output logic signed [safm_pkg::ANGLE_BITS-1:0] angle_deg,
  output logic                                   left_side,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [safm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [safm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  safm_pkg::cfg_t  cfg;
  safm_pkg::item_t front_item;
  safm_pkg::item_t q_head;
  logic            front_push;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            sample_accept;

  // Samples are taken whenever the queue has room.
  assign sample_stall  = q_full;
  assign sample_accept = sample_valid && !sample_stall;
  assign cfg_ready     = 1'b1;

  // Configuration registers. Fields narrower than the data bus take the low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode  <= safm_pkg::RST_FILTER_MODE;
      cfg.lpf_factor   <= safm_pkg::RST_LPF_FACTOR;
      cfg.mean_window  <= safm_pkg::RST_MEAN_WINDOW;
      cfg.center_level <= safm_pkg::RST_CENTER_LEVEL;
      cfg.left_gain    <= safm_pkg::RST_LEFT_GAIN;
      cfg.left_offset  <= safm_pkg::RST_LEFT_OFFSET;
      cfg.right_gain   <= safm_pkg::RST_RIGHT_GAIN;
      cfg.right_offset <= safm_pkg::RST_RIGHT_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        safm_pkg::REG_FILTER_MODE:  cfg.filter_mode  <= cfg_data[0];
        safm_pkg::REG_LPF_FACTOR:   cfg.lpf_factor   <= cfg_data[safm_pkg::FACTOR_BITS-1:0];
        safm_pkg::REG_MEAN_WINDOW:  cfg.mean_window  <= cfg_data[safm_pkg::WINDOW_BITS-1:0];
        safm_pkg::REG_CENTER_LEVEL: cfg.center_level <= cfg_data[safm_pkg::LEVEL_BITS-1:0];
        safm_pkg::REG_LEFT_GAIN:    cfg.left_gain    <= cfg_data;
        safm_pkg::REG_LEFT_OFFSET:  cfg.left_offset  <= $signed(cfg_data);
        safm_pkg::REG_RIGHT_GAIN:   cfg.right_gain   <= cfg_data;
        safm_pkg::REG_RIGHT_OFFSET: cfg.right_offset <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  safm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .accept (sample_accept),
    .push   (front_push),
    .item   (front_item)
  );

  safm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  safm_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .filtered_level (filtered_level),
    .angle_deg      (angle_deg),
    .left_side      (left_side)
  );

endmodule

// ===== src/safm_front.sv =====
`timescale 1ns / 1ps

module safm_front #(
  parameter int SAMPLE_BITS = safm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  safm_pkg::cfg_t         cfg,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   accept,
  output logic                   push,
  output safm_pkg::item_t        item
);

  logic [safm_pkg::SUM_BITS-1:0]    window_sum;
  logic [safm_pkg::WINDOW_BITS-1:0] window_count;
  logic [safm_pkg::SUM_BITS-1:0]    sum_new;
  logic [safm_pkg::WINDOW_BITS-1:0] count_new;
  logic [safm_pkg::WINDOW_BITS-1:0] window_len;
  logic                             window_done;

  // A window length of zero behaves as one.
  assign window_len  = (cfg.mean_window == '0) ? safm_pkg::WINDOW_BITS'(1) : cfg.mean_window;
  assign sum_new     = window_sum + safm_pkg::SUM_BITS'(sample);
  assign count_new   = window_count + safm_pkg::WINDOW_BITS'(1);
  assign window_done = (count_new >= window_len);

  assign push = accept;

  always_comb begin
    item.divisor = window_len;
    if (cfg.filter_mode == safm_pkg::MODE_LPF) begin
      item.kind    = safm_pkg::ITEM_LPF;
      item.operand = safm_pkg::SUM_BITS'(sample);
    end else if (window_done) begin
      item.kind    = safm_pkg::ITEM_MEAN_CLOSE;
      item.operand = sum_new;
    end else begin
      item.kind    = safm_pkg::ITEM_MEAN_HOLD;
      item.operand = sum_new;
    end
  end

  // The running sum is kept across low-pass periods.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      window_count <= '0;
    end else if (accept && cfg.filter_mode == safm_pkg::MODE_MEAN) begin
      if (window_done) begin
        window_sum   <= '0;
        window_count <= '0;
      end else begin
        window_sum   <= sum_new;
        window_count <= count_new;
      end
    end
  end

endmodule

// ===== src/safm_queue.sv =====
`timescale 1ns / 1ps

module safm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  safm_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output safm_pkg::item_t head
);

  localparam int DEPTH    = safm_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  safm_pkg::item_t       entries [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== src/safm_back.sv =====
`timescale 1ns / 1ps

module safm_back #(
  parameter int SAMPLE_BITS = safm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  safm_pkg::cfg_t                      cfg,
  input  logic                                q_not_empty,
  input  safm_pkg::item_t                     q_head,
  output logic                                q_pop,
  input  logic                                result_stall,
  output logic                                result_valid,
  output logic [safm_pkg::LEVEL_BITS-1:0]     filtered_level,
  output logic signed [safm_pkg::ANGLE_BITS-1:0] angle_deg,
  output logic                                left_side
);

  localparam int SB        = SAMPLE_BITS;
  localparam int SUMB      = safm_pkg::SUM_BITS;
  localparam int WB        = safm_pkg::WINDOW_BITS;
  localparam int FB        = safm_pkg::FACTOR_BITS;
  localparam int AB        = safm_pkg::ANGLE_BITS;
  localparam int LPF_A_W   = SB + FB + 1;
  localparam int LPF_B_W   = SB + FB;
  localparam int MAP_W     = SB + safm_pkg::GAIN_BITS;
  localparam int SUM_W     = SB + FB + 2;
  localparam int STEP_BITS = $clog2(safm_pkg::DIV_STEPS);

  localparam logic signed [SUM_W-1:0] ANG_MAX = SUM_W'(32'sd32767);
  localparam logic signed [SUM_W-1:0] ANG_MIN = SUM_W'(-32'sd32768);

  safm_pkg::back_state_t state, state_next;

  logic [SB-1:0]          filtered_value;
  safm_pkg::item_kind_t   kind;
  logic [SUMB-1:0]        operand;
  logic [WB-1:0]          divisor;
  logic [WB-1:0]          remainder;
  logic [STEP_BITS-1:0]   step;
  logic [LPF_A_W-1:0]     lpf_prod_a;
  logic [LPF_B_W-1:0]     lpf_prod_b;
  logic [MAP_W-1:0]       map_prod;
  logic                   map_left;
  logic signed [AB-1:0]   map_offset;

  logic                   out_free;
  logic                   load_out;
  logic                   last_step;
  logic [WB:0]            rem_shift;
  logic                   quot_bit;
  logic [WB-1:0]          rem_next;
  logic [SUMB-1:0]        operand_next;
  logic [LPF_A_W-1:0]     lpf_total;
  logic                   is_left;
  logic signed [SUM_W-1:0] angle_sum;
  logic signed [AB-1:0]   angle_sat;

  assign out_free  = !result_valid || !result_stall;
  assign last_step = (step == STEP_BITS'(safm_pkg::DIV_STEPS - 1));

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_shift    = {remainder, operand[SUMB-1]};
  assign quot_bit     = (rem_shift >= {1'b0, divisor});
  assign rem_next     = quot_bit ? WB'(rem_shift - {1'b0, divisor}) : rem_shift[WB-1:0];
  assign operand_next = {operand[SUMB-2:0], quot_bit};

  assign lpf_total = lpf_prod_a + LPF_A_W'(lpf_prod_b);
  assign is_left   = (safm_pkg::CMP_BITS'(filtered_value) >=
                      safm_pkg::CMP_BITS'(cfg.center_level));

  assign angle_sum = $signed({2'b00, map_prod[MAP_W-1:8]}) + SUM_W'(map_offset);

  always_comb begin
    if (angle_sum > ANG_MAX) begin
      angle_sat = AB'(ANG_MAX);
    end else if (angle_sum < ANG_MIN) begin
      angle_sat = AB'(ANG_MIN);
    end else begin
      angle_sat = angle_sum[AB-1:0];
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      safm_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          case (q_head.kind)
            safm_pkg::ITEM_LPF:        state_next = safm_pkg::BK_LPF_MUL;
            safm_pkg::ITEM_MEAN_CLOSE: state_next = safm_pkg::BK_DIV;
            default:                   state_next = safm_pkg::BK_MAP_MUL;
          endcase
        end
      end
      safm_pkg::BK_LPF_MUL: state_next = safm_pkg::BK_LPF_SUM;
      safm_pkg::BK_LPF_SUM: state_next = safm_pkg::BK_MAP_MUL;
      safm_pkg::BK_DIV: begin
        if (last_step) begin
          state_next = safm_pkg::BK_MAP_MUL;
        end
      end
      safm_pkg::BK_MAP_MUL: state_next = safm_pkg::BK_MAP_ADD;
      safm_pkg::BK_MAP_ADD: begin
        if (out_free) begin
          state_next = safm_pkg::BK_IDLE;
        end
      end
      default: state_next = safm_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      safm_pkg::BK_IDLE:    q_pop    = q_not_empty;
      safm_pkg::BK_MAP_ADD: load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= safm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    case (state)
      safm_pkg::BK_IDLE: begin
        kind      <= q_head.kind;
        operand   <= q_head.operand;
        divisor   <= q_head.divisor;
        remainder <= '0;
        step      <= '0;
      end
      safm_pkg::BK_LPF_MUL: begin
        lpf_prod_a <= LPF_A_W'(operand[SB-1:0]) *
                      LPF_A_W'((FB + 1)'(1 << FB) - (FB + 1)'(cfg.lpf_factor));
        lpf_prod_b <= LPF_B_W'(filtered_value) * LPF_B_W'(cfg.lpf_factor);
      end
      safm_pkg::BK_DIV: begin
        operand   <= operand_next;
        remainder <= rem_next;
        step      <= step + STEP_BITS'(1);
      end
      safm_pkg::BK_MAP_MUL: begin
        map_left   <= is_left;
        map_prod   <= MAP_W'(is_left ? cfg.left_gain : cfg.right_gain) *
                      MAP_W'(filtered_value);
        map_offset <= is_left ? cfg.left_offset : cfg.right_offset;
      end
      default: begin
      end
    endcase
  end

  // The filter state itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_value <= '0;
    end else if (state == safm_pkg::BK_LPF_SUM) begin
      filtered_value <= lpf_total[SB+FB-1:FB];
    end else if (state == safm_pkg::BK_DIV && last_step && kind == safm_pkg::ITEM_MEAN_CLOSE) begin
      filtered_value <= operand_next[SB-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_level <= safm_pkg::LEVEL_BITS'(filtered_value);
      angle_deg      <= angle_sat;
      left_side      <= map_left;
    end
  end

endmodule

// ===== src/safm_checker.sv =====
`timescale 1ns / 1ps

module safm_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   sample_valid,
  input logic                                   sample_stall,
  input logic                                   result_valid,
  input logic                                   result_stall,
  input logic [safm_pkg::LEVEL_BITS-1:0]        filtered_level,
  input logic signed [safm_pkg::ANGLE_BITS-1:0] angle_deg,
  input logic                                   left_side
);

  // Queue entries, the item in the back part and the output register.
  localparam int MAX_IN_FLIGHT = safm_pkg::QUEUE_DEPTH + 2;
  localparam int FLIGHT_BITS   = $clog2(MAX_IN_FLIGHT + 1);

  logic [FLIGHT_BITS-1:0] in_flight;
  logic                   sample_xfer;
  logic                   result_xfer;

  assign sample_xfer = sample_valid && !sample_stall;
  assign result_xfer = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (sample_xfer && !result_xfer) begin
      in_flight <= in_flight + FLIGHT_BITS'(1);
    end else if (result_xfer && !sample_xfer) begin
      in_flight <= in_flight - FLIGHT_BITS'(1);
    end
  end

  // Reset empties the output and opens the input.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("result pending or input stalled after reset");

  // Every result belongs to an accepted sample.
  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    result_xfer |-> in_flight != '0)
    else $error("result delivered with no sample outstanding");

  // The block never holds more samples than it has room for.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    in_flight <= FLIGHT_BITS'(MAX_IN_FLIGHT))
    else $error("more samples in flight than storage allows");

  // A stalled result keeps its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered_level) &&
      $stable(angle_deg) && $stable(left_side))
    else $error("stalled result changed");

endmodule

bind steer_angle_filter_and_map safm_checker u_safm_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_stall   (sample_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .filtered_level (filtered_level),
  .angle_deg      (angle_deg),
  .left_side      (left_side)
);
